FILE: rtl/core/linear_queue_min_max_sum_top_defines.svh
// assertion macros used by the queue rtl
`ifndef LINEAR_QUEUE_MIN_MAX_SUM_TOP_DEFINES_SVH
`define LINEAR_QUEUE_MIN_MAX_SUM_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define LQMMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define LQMMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lqmms_pkg.sv
// types and constants for the linear queue with min, max and sum
`default_nettype none
package lqmms_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam int CNT_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        ACT_ENQ = 1'b0,
        ACT_DEQ = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } t_state;

    typedef struct packed {
        t_action                   action;
        logic signed [DATA_W-1:0]  value_in;
    } t_in_word;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  value_out;
        logic [CNT_W-1:0]          count;
        logic                      is_empty;
        logic                      is_full;
        logic signed [DATA_W-1:0]  min_value;
        logic signed [DATA_W-1:0]  max_value;
        logic signed [DATA_W-1:0]  sum_value;
    } t_out_word;

endpackage
`default_nettype wire

FILE: rtl/core/lqmms_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module lqmms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: rtl/core/lqmms_acc.sv
// running min, max and wrapping sum over scanned entries
`default_nettype none
module lqmms_acc
    import lqmms_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_clr,
    input  wire logic                     i_en,
    input  wire logic signed [DATA_W-1:0] i_data,
    output logic signed      [DATA_W-1:0] o_min,
    output logic signed      [DATA_W-1:0] o_max,
    output logic signed      [DATA_W-1:0] o_sum
);

    logic signed [DATA_W-1:0] r_min;
    logic signed [DATA_W-1:0] r_max;
    logic signed [DATA_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_min <= INT_MAX;
            r_max <= INT_MIN;
            r_sum <= '0;
        end else if (i_en) begin
            if (i_data < r_min) begin
                r_min <= i_data;
            end
            if (i_data > r_max) begin
                r_max <= i_data;
            end
            r_sum <= r_sum + i_data;
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;
    assign o_sum = r_sum;

endmodule
`default_nettype wire

FILE: rtl/core/linear_queue_min_max_sum_top.sv
// linear array queue of signed words reporting count, min, max and sum
//
// input channel: i_in_valid / o_in_ready with i_in_word (action, value_in).
// action enqueue stores value_in at the write position, dequeue pops the head.
// output channel: o_out_valid / i_out_ready with o_out_word, one word per
// input word, in order.
// config channel: i_cfg_valid / o_cfg_ready with i_cfg_data, the capacity.
// after a word is accepted, the scan reads the slot ram once per cycle over
// the n entries held after the step (up to DEPTH) to rebuild min, max and
// sum; the result then passes through S_HOLD into the output register.
// one word is processed at a time: no new word is accepted until the
// previous one has reached the output register.
// the result sits in an output register, so the next word is accepted while
// the previous result waits; that word then waits before its own result.
// a dequeue that empties the queue returns both positions to zero; the queue
// reports full once the write position reaches capacity.
// reset (synchronous, active low) empties the queue and sets capacity to 16;
// slot contents are not cleared.
`default_nettype none
module linear_queue_min_max_sum_top
    import lqmms_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_word         i_in_word,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_word             o_out_word,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CAP_W-1:0] i_cfg_data
);

    `include "linear_queue_min_max_sum_top_defines.svh"

    localparam int PW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (PW > CAP_W) ? PW : CAP_W;

    t_state           r_state, n_state;
    logic [PW-1:0]    r_head, n_head;
    logic [PW-1:0]    r_wpos, n_wpos;
    logic [PW-1:0]    r_ptr;
    logic [CAP_W-1:0] r_cap;
    logic             r_pend;
    logic             r_pend_deq;
    t_status          r_status, n_status;
    logic signed [DATA_W-1:0] r_vout;
    logic             r_out_valid;
    t_out_word        r_out_word;

    logic             in_acc;
    logic             deq_rd;
    logic             enq_wr;
    logic             scan_issue;
    logic             out_free;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic [CW-1:0]    cap_ext;
    logic [CW-1:0]    eff_cap;
    logic [CW-1:0]    cnt_ext;
    logic             full_now;
    logic [PW-1:0]    head_inc;
    logic signed [DATA_W-1:0] acc_min, acc_max, acc_sum;

    // effective capacity: zero acts as one, clipped to the ram depth
    always_comb begin
        cap_ext = CW'(r_cap);
        if (r_cap == '0) begin
            eff_cap = CW'(1);
        end else if (cap_ext > CW'(DEPTH)) begin
            eff_cap = CW'(DEPTH);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign full_now = CW'(r_wpos) >= eff_cap;
    assign cnt_ext  = CW'(r_wpos) - CW'(r_head);
    assign head_inc = r_head + PW'(1);
    assign out_free = !r_out_valid || i_out_ready;
    assign in_acc   = i_in_valid && o_in_ready;

    // operation decode on the accepted word
    always_comb begin
        n_head   = r_head;
        n_wpos   = r_wpos;
        n_status = ST_DONE;
        enq_wr   = 1'b0;
        deq_rd   = 1'b0;
        if (i_in_word.action == ACT_ENQ) begin
            if (full_now) begin
                n_status = ST_FULL;
            end else begin
                enq_wr = 1'b1;
                n_wpos = r_wpos + PW'(1);
            end
        end else begin
            if (r_head >= r_wpos) begin
                n_status = ST_EMPTY;
            end else begin
                deq_rd = 1'b1;
                if (head_inc >= r_wpos) begin
                    n_head = '0;
                    n_wpos = '0;
                end else begin
                    n_head = head_inc;
                end
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!scan_issue && !r_pend) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        scan_issue = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = r_head[AW-1:0];
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                ram_re     = i_in_valid && deq_rd;
            end
            S_SCAN: begin
                scan_issue = r_ptr < r_wpos;
                ram_re     = scan_issue;
                ram_raddr  = r_ptr[AW-1:0];
            end
            S_HOLD: begin
                o_in_ready = 1'b0;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_wpos      <= '0;
            r_cap       <= CAP_RESET;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (in_acc) begin
                r_head <= n_head;
                r_wpos <= n_wpos;
                r_pend <= deq_rd;
            end else if (r_state == S_SCAN) begin
                r_pend <= scan_issue;
            end
            if (r_state == S_HOLD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ptr      <= n_head;
            r_status   <= n_status;
            r_vout     <= '0;
            r_pend_deq <= deq_rd;
        end else if (r_state == S_SCAN) begin
            if (scan_issue) begin
                r_ptr <= r_ptr + PW'(1);
            end
            r_pend_deq <= 1'b0;
            if (r_pend && r_pend_deq) begin
                r_vout <= ram_rdata;
            end
        end
        if (r_state == S_HOLD && out_free) begin
            r_out_word.status    <= r_status;
            r_out_word.value_out <= r_vout;
            r_out_word.count     <= cnt_ext[CNT_W-1:0];
            r_out_word.is_empty  <= r_head == r_wpos;
            r_out_word.is_full   <= full_now;
            r_out_word.min_value <= acc_min;
            r_out_word.max_value <= acc_max;
            r_out_word.sum_value <= acc_sum;
        end
    end

    lqmms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (in_acc && enq_wr),
        .i_waddr (r_wpos[AW-1:0]),
        .i_wdata (i_in_word.value_in),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lqmms_acc u_acc (
        .i_clk  (i_clk),
        .i_clr  (in_acc),
        .i_en   (r_state == S_SCAN && r_pend && !r_pend_deq),
        .i_data (ram_rdata),
        .o_min  (acc_min),
        .o_max  (acc_max),
        .o_sum  (acc_sum)
    );

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `LQMMS_ASSERT_NOW(a_head_le_wpos, 1'b1, r_head <= r_wpos, "head passed write position")
    `LQMMS_ASSERT_NOW(a_wpos_le_depth, 1'b1, r_wpos <= PW'(DEPTH),
                      "write position beyond depth")
    `LQMMS_ASSERT_NEXT(a_enq_adv, in_acc && enq_wr, r_wpos == $past(r_wpos) + PW'(1),
                       "enqueue did not advance")
    `LQMMS_ASSERT_NOW(a_idle_no_pend, r_state == S_IDLE, !r_pend, "ram read pending while idle")
    `LQMMS_ASSERT_NOW(a_empty_out, o_out_valid && o_out_word.is_empty,
                      o_out_word.count == '0 && o_out_word.sum_value == '0 &&
                      o_out_word.min_value == INT_MAX,
                      "empty result not neutral")

endmodule
`default_nettype wire
